// File: rtl/assert_macros.svh
// Shared assertion macros; the user module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define E2Q_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define E2Q_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/e2q_pkg.sv
package e2q_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int OUT_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS    = 28;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cs_t;

  typedef struct packed {
    cs_t roll;
    cs_t pitch;
    cs_t yaw;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] sr;
    logic signed [31:0] cp;
    logic signed [31:0] sp;
    logic signed [31:0] cy;
    logic signed [31:0] sy;
  } trig_t;

  function automatic logic signed [31:0] atan_unit(input int step);
    logic signed [31:0] r;
    case (step)
      0:       r = 32'sd536870912;
      1:       r = 32'sd316933406;
      2:       r = 32'sd167458907;
      3:       r = 32'sd85004756;
      4:       r = 32'sd42667331;
      5:       r = 32'sd21354465;
      6:       r = 32'sd10680862;
      7:       r = 32'sd5340245;
      8:       r = 32'sd2670163;
      9:       r = 32'sd1335087;
      10:      r = 32'sd667544;
      11:      r = 32'sd333772;
      12:      r = 32'sd166886;
      13:      r = 32'sd83443;
      14:      r = 32'sd41722;
      15:      r = 32'sd20861;
      16:      r = 32'sd10430;
      17:      r = 32'sd5215;
      18:      r = 32'sd2608;
      19:      r = 32'sd1304;
      20:      r = 32'sd652;
      21:      r = 32'sd326;
      22:      r = 32'sd163;
      23:      r = 32'sd81;
      24:      r = 32'sd41;
      25:      r = 32'sd20;
      26:      r = 32'sd10;
      27:      r = 32'sd5;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/e2q_cordic_cell.sv
module e2q_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  e2q_pkg::cell_t  data_i,
  input  logic            en_i,
  output logic            valid_o,
  output e2q_pkg::cell_t  data_o,
  output logic            en_o
);

  localparam logic signed [31:0] ATAN = e2q_pkg::atan_unit(STEP);

  function automatic e2q_pkg::cs_t rot(input e2q_pkg::cs_t a);
    e2q_pkg::cs_t r;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    dx = a.x >>> STEP;
    dy = a.y >>> STEP;
    if (!a.z[31]) begin
      r.x = a.x - dy;
      r.y = a.y + dx;
      r.z = a.z - ATAN;
    end else begin
      r.x = a.x + dy;
      r.y = a.y - dx;
      r.z = a.z + ATAN;
    end
    return r;
  endfunction

  logic           valid_q;
  e2q_pkg::cell_t data_q;
  e2q_pkg::cell_t data_d;

  assign en_o = !valid_q || en_i;

  always_comb begin
    data_d.roll  = rot(data_i.roll);
    data_d.pitch = rot(data_i.pitch);
    data_d.yaw   = rot(data_i.yaw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/e2q_product.sv
module e2q_product #(
  parameter int OUT_WIDTH = e2q_pkg::OUT_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  e2q_pkg::trig_t              trig_i,
  output logic                        en_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [OUT_WIDTH-1:0] quat_w_o,
  output logic signed [OUT_WIDTH-1:0] quat_x_o,
  output logic signed [OUT_WIDTH-1:0] quat_y_o,
  output logic signed [OUT_WIDTH-1:0] quat_z_o
);

  localparam int NS = 6;
  localparam int SH = 32 - OUT_WIDTH;
  localparam logic signed [33:0] RND     = (34'sd1 <<< SH) >>> 1;
  localparam logic signed [33:0] ONE     = 34'sd1 <<< (OUT_WIDTH - 2);
  localparam logic signed [33:0] NEG_ONE = -ONE;
  localparam logic signed [63:0] HALF    = 64'sd1 <<< 29;

  function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] m);
    logic signed [63:0] s;
    s = m + HALF;
    return s[61:30];
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [32:0] v);
    logic signed [33:0] a;
    a = 34'(v) + RND;
    a = a >>> SH;
    if (a > ONE) begin
      a = ONE;
    end else if (a < NEG_ONE) begin
      a = NEG_ONE;
    end
    return a[OUT_WIDTH-1:0];
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic signed [63:0] m_cc_q, m_ss_q, m_sc_q, m_cs_q;
  logic signed [31:0] cr0_q, sr0_q;
  logic signed [31:0] p_cc_q, p_ss_q, p_sc_q, p_cs_q;
  logic signed [31:0] cr1_q, sr1_q;
  logic signed [63:0] t_q [8];
  logic signed [31:0] r_q [8];
  logic signed [32:0] s_w_q, s_x_q, s_y_q, s_z_q;
  logic signed [OUT_WIDTH-1:0] qw_q, qx_q, qy_q, qz_q;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign en_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m_cc_q <= $signed(trig_i.cy) * $signed(trig_i.cp);
      m_ss_q <= $signed(trig_i.sy) * $signed(trig_i.sp);
      m_sc_q <= $signed(trig_i.sy) * $signed(trig_i.cp);
      m_cs_q <= $signed(trig_i.cy) * $signed(trig_i.sp);
      cr0_q  <= trig_i.cr;
      sr0_q  <= trig_i.sr;
    end
    if (en[1]) begin
      p_cc_q <= rnd_q30(m_cc_q);
      p_ss_q <= rnd_q30(m_ss_q);
      p_sc_q <= rnd_q30(m_sc_q);
      p_cs_q <= rnd_q30(m_cs_q);
      cr1_q  <= cr0_q;
      sr1_q  <= sr0_q;
    end
    if (en[2]) begin
      t_q[0] <= p_cc_q * cr1_q;
      t_q[1] <= p_ss_q * sr1_q;
      t_q[2] <= p_cc_q * sr1_q;
      t_q[3] <= p_ss_q * cr1_q;
      t_q[4] <= p_sc_q * sr1_q;
      t_q[5] <= p_cs_q * cr1_q;
      t_q[6] <= p_sc_q * cr1_q;
      t_q[7] <= p_cs_q * sr1_q;
    end
    if (en[3]) begin
      for (int k = 0; k < 8; k++) begin
        r_q[k] <= rnd_q30(t_q[k]);
      end
    end
    if (en[4]) begin
      s_w_q <= 33'(r_q[0]) + 33'(r_q[1]);
      s_x_q <= 33'(r_q[2]) - 33'(r_q[3]);
      s_y_q <= 33'(r_q[4]) + 33'(r_q[5]);
      s_z_q <= 33'(r_q[6]) - 33'(r_q[7]);
    end
    if (en[5]) begin
      qw_q <= to_out(s_w_q);
      qx_q <= to_out(s_x_q);
      qy_q <= to_out(s_y_q);
      qz_q <= to_out(s_z_q);
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign quat_w_o    = qw_q;
  assign quat_x_o    = qx_q;
  assign quat_y_o    = qy_q;
  assign quat_z_o    = qz_q;

endmodule

// File: rtl/euler_to_quaternion.sv
// Converts roll, pitch and yaw binary angles into a ZYX unit quaternion in signed
// Q1.(OUT_WIDTH-2), each component saturated to plus or minus one. Every angle is
// halved and run through a row of 28 CORDIC cells, one rotation step per cell, all
// three angles side by side; six product stages then form, round and combine the
// triple products. One item enters per cycle while in_ready_o is high. Each stage
// takes new data whenever it is empty or its successor moves, so in_ready_o
// follows out_ready_i combinationally back through the row and stays high while
// any bubble is still in the pipeline.
module euler_to_quaternion #(
  parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int OUT_WIDTH   = e2q_pkg::OUT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [OUT_WIDTH-1:0]   quat_w_o,
  output logic signed [OUT_WIDTH-1:0]   quat_x_o,
  output logic signed [OUT_WIDTH-1:0]   quat_y_o,
  output logic signed [OUT_WIDTH-1:0]   quat_z_o
);

  localparam int N = e2q_pkg::CORDIC_STEPS;

  function automatic e2q_pkg::cs_t seed(input logic signed [ANGLE_WIDTH-1:0] a);
    e2q_pkg::cs_t       r;
    logic signed [32:0] h;
    h   = 33'(a);
    h   = (h <<< (32 - ANGLE_WIDTH)) >>> 1;
    r.x = e2q_pkg::CORDIC_GAIN;
    r.y = 32'sd0;
    r.z = h[31:0];
    return r;
  endfunction

  logic           valid_w [N+1];
  e2q_pkg::cell_t data_w  [N+1];
  logic           en_w    [N+1];
  e2q_pkg::trig_t trig;

  assign valid_w[0]      = in_valid_i;
  assign data_w[0].roll  = seed(roll_angle_i);
  assign data_w[0].pitch = seed(pitch_angle_i);
  assign data_w[0].yaw   = seed(yaw_angle_i);
  assign in_ready_o      = en_w[0];

  for (genvar k = 0; k < N; k++) begin : g_cell
    e2q_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_w[k]),
      .data_i (data_w[k]),
      .en_i   (en_w[k+1]),
      .valid_o(valid_w[k+1]),
      .data_o (data_w[k+1]),
      .en_o   (en_w[k])
    );
  end

  assign trig.cr = data_w[N].roll.x;
  assign trig.sr = data_w[N].roll.y;
  assign trig.cp = data_w[N].pitch.x;
  assign trig.sp = data_w[N].pitch.y;
  assign trig.cy = data_w[N].yaw.x;
  assign trig.sy = data_w[N].yaw.y;

  e2q_product #(
    .OUT_WIDTH(OUT_WIDTH)
  ) u_product (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_w[N]),
    .trig_i     (trig),
    .en_o       (en_w[N]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .quat_w_o   (quat_w_o),
    .quat_x_o   (quat_x_o),
    .quat_y_o   (quat_y_o),
    .quat_z_o   (quat_z_o)
  );

endmodule

// File: rtl/e2q_checker.sv
`include "assert_macros.svh"

module e2q_checker #(
  parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int OUT_WIDTH   = e2q_pkg::OUT_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  input logic signed [ANGLE_WIDTH-1:0] yaw_angle_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [OUT_WIDTH-1:0]   quat_w_o,
  input logic signed [OUT_WIDTH-1:0]   quat_x_o,
  input logic signed [OUT_WIDTH-1:0]   quat_y_o,
  input logic signed [OUT_WIDTH-1:0]   quat_z_o
);

  localparam logic signed [OUT_WIDTH-1:0] ONE     = OUT_WIDTH'(1) <<< (OUT_WIDTH - 2);
  localparam logic signed [OUT_WIDTH-1:0] NEG_ONE = -ONE;

  logic in_hold;
  logic out_hold;
  logic w_ok;
  logic x_ok;
  logic y_ok;
  logic z_ok;

  assign in_hold  = in_valid_i && !in_ready_o;
  assign out_hold = out_valid_o && !out_ready_i;
  assign w_ok     = (quat_w_o <= ONE) && (quat_w_o >= NEG_ONE);
  assign x_ok     = (quat_x_o <= ONE) && (quat_x_o >= NEG_ONE);
  assign y_ok     = (quat_y_o <= ONE) && (quat_y_o >= NEG_ONE);
  assign z_ok     = (quat_z_o <= ONE) && (quat_z_o >= NEG_ONE);

  `E2Q_ASSERT(a_out_hold, out_hold |=> out_valid_o && $stable(quat_w_o) && $stable(quat_x_o) && $stable(quat_y_o) && $stable(quat_z_o), "stalled result changed")
  `E2Q_ASSERT(a_in_hold, in_hold |=> in_valid_i && $stable(roll_angle_i) && $stable(pitch_angle_i) && $stable(yaw_angle_i), "offered input changed")
  `E2Q_ASSERT(a_range, out_valid_o |-> w_ok && x_ok && y_ok && z_ok, "component beyond one")
  `E2Q_ASSERT(a_ready_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")
  `E2Q_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> !out_valid_o, "result present after reset")

endmodule

bind euler_to_quaternion e2q_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH),
  .OUT_WIDTH  (OUT_WIDTH)
) u_e2q_checker (.*);

// File: sim/tb_top.sv
class quat_scoreboard;

  localparam int AW = e2q_pkg::ANGLE_WIDTH_DEF;
  localparam int OW = e2q_pkg::OUT_WIDTH_DEF;
  localparam int STEPS = 28;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam int OUT_SHIFT = 30 - (OW - 2);
  localparam longint UNIT_OUT = longint'(1) <<< (OW - 2);
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
    logic signed [OW-1:0] w;
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } quat_entry_t;

  longint atan_steps [STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5
  };

  quat_entry_t pending_quats [$];
  int mismatches;
  int checked;

  function void half_trig(input logic signed [AW-1:0] ang, output longint c, output longint s);
    longint xv, yv, zv, dx, dy;
    xv = GAIN_Q30;
    yv = 0;
    zv = (longint'(ang) <<< (32 - AW)) >>> 1;
    for (int i = 0; i < STEPS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (zv >= 0) begin
        xv = xv - dx;
        yv = yv + dy;
        zv = zv - atan_steps[i];
      end else begin
        xv = xv + dx;
        yv = yv - dy;
        zv = zv + atan_steps[i];
      end
    end
    c = xv;
    s = yv;
  endfunction

  function longint mul_q30(input longint a, input longint b);
    return (a * b + HALF_Q30) >>> 30;
  endfunction

  function longint triple(input longint a, input longint b, input longint c);
    return mul_q30(mul_q30(a, b), c);
  endfunction

  function logic signed [OW-1:0] to_q14(input longint v);
    longint r;
    if (OUT_SHIFT == 0) begin
      r = v;
    end else begin
      r = (v + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    end
    if (r > UNIT_OUT) begin
      r = UNIT_OUT;
    end
    if (r < -UNIT_OUT) begin
      r = -UNIT_OUT;
    end
    return r[OW-1:0];
  endfunction

  function void note_input(input logic signed [AW-1:0] roll, input logic signed [AW-1:0] pitch,
                           input logic signed [AW-1:0] yaw);
    longint cr, sr, cp, sp, cy, sy;
    quat_entry_t q;
    half_trig(roll, cr, sr);
    half_trig(pitch, cp, sp);
    half_trig(yaw, cy, sy);
    q.roll  = roll;
    q.pitch = pitch;
    q.yaw   = yaw;
    q.w = to_q14(triple(cy, cp, cr) + triple(sy, sp, sr));
    q.x = to_q14(triple(cy, cp, sr) - triple(sy, sp, cr));
    q.y = to_q14(triple(sy, cp, sr) + triple(cy, sp, cr));
    q.z = to_q14(triple(sy, cp, cr) - triple(cy, sp, sr));
    pending_quats.push_back(q);
  endfunction

  function void check_result(input logic signed [OW-1:0] w, input logic signed [OW-1:0] x,
                             input logic signed [OW-1:0] y, input logic signed [OW-1:0] z);
    quat_entry_t q;
    if (pending_quats.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("unexpected quaternion w=%0d x=%0d y=%0d z=%0d", w, x, y, z);
      end
      return;
    end
    q = pending_quats.pop_front();
    checked++;
    if (w !== q.w || x !== q.x || y !== q.y || z !== q.z) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("angles r=%0d p=%0d y=%0d: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                 q.roll, q.pitch, q.yaw, q.w, q.x, q.y, q.z, w, x, y, z);
      end
    end
  endfunction

  function int pending_count();
    return pending_quats.size();
  endfunction

endclass

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = e2q_pkg::ANGLE_WIDTH_DEF;
  localparam int OW = e2q_pkg::OUT_WIDTH_DEF;
  localparam int LATENCY = 34;
  localparam int N_RANDOM = 800;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT_CYCLES = 300000;
  localparam logic signed [AW-1:0] ANG_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [AW-1:0] ANG_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ANG_HALF = {2'b01, {(AW-2){1'b0}}};
  localparam logic signed [AW-1:0] ANG_QUARTER = {3'b001, {(AW-3){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [AW-1:0] roll_angle_i = '0;
  logic signed [AW-1:0] pitch_angle_i = '0;
  logic signed [AW-1:0] yaw_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OW-1:0] quat_w_o;
  logic signed [OW-1:0] quat_x_o;
  logic signed [OW-1:0] quat_y_o;
  logic signed [OW-1:0] quat_z_o;

  quat_scoreboard sb = new();
  int accepted;
  int directed_count;
  int long_holds;
  int cycle_count;

  euler_to_quaternion uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .roll_angle_i (roll_angle_i),
    .pitch_angle_i(pitch_angle_i),
    .yaw_angle_i  (yaw_angle_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .quat_w_o     (quat_w_o),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_input(roll_angle_i, pitch_angle_i, yaw_angle_i);
        accepted <= accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(quat_w_o, quat_x_o, quat_y_o, quat_z_o);
      end
    end
  end

  task automatic send_item(input logic signed [AW-1:0] r, input logic signed [AW-1:0] p,
                           input logic signed [AW-1:0] y);
    in_valid_i    <= 1'b1;
    roll_angle_i  <= r;
    pitch_angle_i <= p;
    yaw_angle_i   <= y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_for(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic signed [AW-1:0] rand_angle();
    int pick;
    logic signed [AW-1:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      a = AW'($urandom());
    end else if (pick < 85) begin
      case ($urandom_range(0, 6))
        0: a = ANG_MIN;
        1: a = ANG_MAX;
        2: a = '0;
        3: a = ANG_HALF;
        4: a = -ANG_HALF;
        5: a = ANG_MIN + AW'($urandom_range(0, 15));
        default: a = ANG_MAX - AW'($urandom_range(0, 15));
      endcase
    end else begin
      a = AW'($signed($urandom_range(0, 511)) - 256);
    end
    return a;
  endfunction

  initial begin : receiver
    int rx_cycles;
    int phase_left;
    int stall_pct;
    rx_cycles = 0;
    phase_left = 0;
    stall_pct = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_cycles == 150 || rx_cycles == 1500) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_cycles += HOLD_CYCLES;
        long_holds++;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 200);
          stall_pct = $urandom_range(0, 3) * 30;
        end
        phase_left--;
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
        @(posedge clk_i);
        rx_cycles++;
      end
    end
  end

  initial begin : stimulus
    int burst_len;
    int gap;
    int sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item('0, '0, '0);
    send_item(ANG_MIN, '0, '0);
    send_item('0, ANG_MIN, '0);
    send_item('0, '0, ANG_MIN);
    send_item(ANG_MIN, ANG_MIN, ANG_MIN);
    send_item(ANG_MAX, '0, '0);
    send_item('0, ANG_MAX, '0);
    send_item('0, '0, ANG_MAX);
    send_item(ANG_MAX, ANG_MAX, ANG_MAX);
    send_item(ANG_MIN, ANG_MAX, ANG_MIN);
    send_item(ANG_MAX, ANG_MIN, ANG_MAX);
    send_item(ANG_HALF, '0, '0);
    send_item('0, ANG_HALF, '0);
    send_item('0, '0, ANG_HALF);
    send_item(-ANG_HALF, -ANG_HALF, -ANG_HALF);
    send_item(ANG_HALF, ANG_HALF, ANG_HALF);
    send_item(ANG_QUARTER, ANG_QUARTER, ANG_QUARTER);
    send_item(16'sd1, -16'sd1, 16'sd1);
    send_item(-16'sd1, 16'sd1, -16'sd1);
    send_item(ANG_MAX, ANG_HALF, -ANG_HALF);
    send_item(16'h5555, 16'hAAAA, 16'h5555);
    send_item(16'hAAAA, 16'h5555, 16'hAAAA);
    directed_count = 22;
    idle_for($urandom_range(1, 8));

    sent = 0;
    while (sent < N_RANDOM) begin
      burst_len = $urandom_range(1, 40);
      for (int i = 0; i < burst_len && sent < N_RANDOM; i++) begin
        send_item(rand_angle(), rand_angle(), rand_angle());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        idle_for(gap);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    if (sb.pending_count() != 0) begin
      $display("%0d quaternions never arrived", sb.pending_count());
    end
    $display("Sent %0d angle triples (%0d directed, extremes and -pi included), %0d quaternions checked",
             accepted, directed_count, sb.checked);
    $display("Output side held off %0d times for %0d cycles with the input still offered",
             long_holds, HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
